### rtl/lome_pkg.sv
// Shared types and codes for the limit order matching engine.
`timescale 1ns / 1ps
package lome_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_DECIDE,
        ST_WRB,
        ST_WRA
    } state_t;

    typedef enum logic {
        PH_LOOKUP,
        PH_BEST
    } phase_t;

    localparam logic       ACT_ADD       = 1'b0;
    localparam logic       ACT_CANCEL    = 1'b1;
    localparam logic       KIND_TRADE    = 1'b0;
    localparam logic       KIND_ACK      = 1'b1;
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_DUP      = 2'd3;

    localparam int ID_BITS  = 64;
    localparam int QTY_BITS = 32;
    localparam int ARR_BITS = 32;

endpackage

### rtl/lome_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module lome_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/lome_scan.sv
// Table walk accumulator: id lookup and best bid / best ask selection.
`timescale 1ns / 1ps
module lome_scan import lome_pkg::*; #(
    parameter int IW = 5,
    parameter int PB = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clr,
    input  logic                in_vld,
    input  logic [IW-1:0]       in_idx,
    input  logic                in_live,
    input  logic                in_buy,
    input  logic [PB-1:0]       in_price,
    input  logic [ID_BITS-1:0]  in_ident,
    input  logic [QTY_BITS-1:0] in_rem,
    input  logic [ARR_BITS-1:0] in_arr,
    input  logic [ID_BITS-1:0]  key_id,
    input  logic [ARR_BITS-1:0] ctr,
    output logic                hit,
    output logic [IW-1:0]       hit_idx,
    output logic                bid_ok,
    output logic [IW-1:0]       bid_idx,
    output logic [PB-1:0]       bid_px,
    output logic [ID_BITS-1:0]  bid_id,
    output logic [QTY_BITS-1:0] bid_rem,
    output logic [ARR_BITS-1:0] bid_arr,
    output logic                ask_ok,
    output logic [IW-1:0]       ask_idx,
    output logic [PB-1:0]       ask_px,
    output logic [ID_BITS-1:0]  ask_id,
    output logic [QTY_BITS-1:0] ask_rem,
    output logic [ARR_BITS-1:0] ask_arr
);
    logic [ARR_BITS-1:0] age, bage, aage;
    logic                take_bid, take_ask;

    always_comb begin
        age      = ctr - in_arr;
        bage     = ctr - bid_arr;
        aage     = ctr - ask_arr;
        take_bid = in_vld && in_live && in_buy &&
                   (!bid_ok || in_price > bid_px ||
                    (in_price == bid_px && age > bage));
        take_ask = in_vld && in_live && !in_buy &&
                   (!ask_ok || in_price < ask_px ||
                    (in_price == ask_px && age > aage));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            hit    <= 1'b0;
            bid_ok <= 1'b0;
            ask_ok <= 1'b0;
        end else begin
            if (in_vld && in_live && in_ident == key_id) begin
                hit     <= 1'b1;
                hit_idx <= in_idx;
            end
            if (take_bid) begin
                bid_ok  <= 1'b1;
                bid_idx <= in_idx;
                bid_px  <= in_price;
                bid_id  <= in_ident;
                bid_rem <= in_rem;
                bid_arr <= in_arr;
            end
            if (take_ask) begin
                ask_ok  <= 1'b1;
                ask_idx <= in_idx;
                ask_px  <= in_price;
                ask_id  <= in_ident;
                ask_rem <= in_rem;
                ask_arr <= in_arr;
            end
        end
    end
endmodule

### rtl/limit_order_matching_engine.sv
// Price-time priority limit order book: top level with sequencer and output register.
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser is the action
//   (0 add, 1 cancel). Results leave on m_tvalid/m_tready/m_tdata/m_tuser/m_tlast;
//   m_tuser is the kind (0 trade, 1 acknowledgement) and m_tlast marks the
//   acknowledgement, which is always the final result of an item.
//   One item is worked at a time; s_tready is high only while the engine is idle.
//   Every walk of the order table reads each slot in turn through the single
//   read port of the slot RAM. An item costs one lookup walk, an action step and
//   one best-price walk, plus for each fill a decision step, a bid write-back, an
//   ask write-back and another best-price walk.
//   Reset clears the live flags, the arrival counter and the output valid flag;
//   slot contents need no clearing since entries of slots that are not live are ignored.
//   When the receiver stalls, the pending result is held in the output register
//   and the sequencer waits before producing the next result.
`timescale 1ns / 1ps
module limit_order_matching_engine import lome_pkg::*; #(
    parameter int ORDER_SLOTS = 32,
    parameter int PRICE_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // order_id[63:0], is_buy[64], limit_price[80:65], order_quantity[112:81]
    input  logic [119:0] s_tdata,
    // action[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], buyer_id[65:2], seller_id[129:66], trade_price[145:130],
    // trade_quantity[177:146], top_bid[193:178], top_ask[209:194]
    output logic [215:0] m_tdata,
    // kind[0]
    output logic         m_tuser,
    output logic         m_tlast
);
    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam int EW = 1 + PRICE_BITS + ID_BITS + QTY_BITS + ARR_BITS;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [ORDER_SLOTS-1:0] live_reg, live_next;
    logic [ARR_BITS-1:0] ctr_reg, ctr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                pv_reg, pv_next;
    logic [IW-1:0]       pidx_reg, pidx_next;
    logic                allow_reg, allow_next;
    logic [1:0]          status_reg, status_next;
    logic [QTY_BITS-1:0] q_reg, q_next;

    logic                act_reg, act_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic                buy_reg, buy_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0] qty_reg, qty_next;

    logic                mv_reg, mv_next;
    logic [215:0]        md_reg, md_next;
    logic                mu_reg, mu_next;
    logic                ml_reg, ml_next;

    logic                we;
    logic [IW-1:0]       waddr, raddr;
    logic [EW-1:0]       wdata, rdata;
    logic                clr;

    logic                hit, bid_ok, ask_ok;
    logic [IW-1:0]       hit_idx, bid_idx, ask_idx;
    logic [PRICE_BITS-1:0] bid_px, ask_px;
    logic [ID_BITS-1:0]  bid_id, ask_id;
    logic [QTY_BITS-1:0] bid_rem, ask_rem, rem_left;
    logic [ARR_BITS-1:0] bid_arr, ask_arr;

    logic                full;
    logic [IW-1:0]       free_idx;
    logic                out_free;

    lome_ram #(.WIDTH(EW), .DEPTH(ORDER_SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    lome_scan #(.IW(IW), .PB(PRICE_BITS)) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (clr),
        .in_vld    (pv_reg),
        .in_idx    (pidx_reg),
        .in_live   (live_reg[pidx_reg]),
        .in_buy    (rdata[EW-1]),
        .in_price  (rdata[EW-2 -: PRICE_BITS]),
        .in_ident  (rdata[ARR_BITS+QTY_BITS +: ID_BITS]),
        .in_rem    (rdata[ARR_BITS +: QTY_BITS]),
        .in_arr    (rdata[ARR_BITS-1:0]),
        .key_id    (id_reg),
        .ctr       (ctr_reg),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .bid_ok    (bid_ok),
        .bid_idx   (bid_idx),
        .bid_px    (bid_px),
        .bid_id    (bid_id),
        .bid_rem   (bid_rem),
        .bid_arr   (bid_arr),
        .ask_ok    (ask_ok),
        .ask_idx   (ask_idx),
        .ask_px    (ask_px),
        .ask_id    (ask_id),
        .ask_rem   (ask_rem),
        .ask_arr   (ask_arr)
    );

    // lowest free slot
    always_comb begin
        full     = 1'b1;
        free_idx = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                full     = 1'b0;
                free_idx = IW'(i);
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;
    assign out_free = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            live_reg  <= '0;
            ctr_reg   <= '0;
            mv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            ctr_reg   <= ctr_next;
            mv_reg    <= mv_next;
            pv_reg    <= pv_next;
        end
        phase_reg  <= phase_next;
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        allow_reg  <= allow_next;
        status_reg <= status_next;
        q_reg      <= q_next;
        act_reg    <= act_next;
        id_reg     <= id_next;
        buy_reg    <= buy_next;
        price_reg  <= price_next;
        qty_reg    <= qty_next;
        md_reg     <= md_next;
        mu_reg     <= mu_next;
        ml_reg     <= ml_next;
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        live_next   = live_reg;
        ctr_next    = ctr_reg;
        cnt_next    = cnt_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        allow_next  = allow_reg;
        status_next = status_reg;
        q_next      = q_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        buy_next    = buy_reg;
        price_next  = price_reg;
        qty_next    = qty_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        mu_next     = mu_reg;
        ml_next     = ml_reg;
        we          = 1'b0;
        waddr       = free_idx;
        wdata       = {buy_reg, price_reg, id_reg, qty_reg, ctr_reg};
        raddr       = cnt_reg[IW-1:0];
        clr         = 1'b0;
        rem_left    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next    = s_tuser;
                    id_next     = s_tdata[63:0];
                    buy_next    = s_tdata[64];
                    price_next  = PRICE_BITS'(s_tdata[80:65]);
                    qty_next    = s_tdata[112:81];
                    status_next = STAT_OK;
                    allow_next  = 1'b0;
                    phase_next  = PH_LOOKUP;
                    cnt_next    = '0;
                    clr         = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg < CW'(ORDER_SLOTS)) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[IW-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end else begin
                    state_next = (phase_reg == PH_LOOKUP) ? ST_ACT : ST_DECIDE;
                end
            end
            ST_ACT: begin
                if (act_reg == ACT_CANCEL) begin
                    if (hit) begin
                        live_next[hit_idx] = 1'b0;
                    end else begin
                        status_next = STAT_NOTFOUND;
                    end
                end else if (hit) begin
                    status_next = STAT_DUP;
                end else if (qty_reg != '0) begin
                    if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        we                  = 1'b1;
                        live_next[free_idx] = 1'b1;
                        ctr_next            = ctr_reg + 1'b1;
                        allow_next          = 1'b1;
                    end
                end
                phase_next = PH_BEST;
                cnt_next   = '0;
                clr        = 1'b1;
                state_next = ST_SCAN;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    if (allow_reg && bid_ok && ask_ok && bid_px >= ask_px) begin
                        q_next  = (bid_rem < ask_rem) ? bid_rem : ask_rem;
                        mu_next = KIND_TRADE;
                        ml_next = 1'b0;
                        md_next = {6'd0, 16'd0, 16'd0,
                                   ((bid_rem < ask_rem) ? bid_rem : ask_rem),
                                   16'(bid_px), ask_id, bid_id, STAT_OK};
                        state_next = ST_WRB;
                    end else begin
                        mu_next = KIND_ACK;
                        ml_next = 1'b1;
                        md_next = {6'd0,
                                   (ask_ok ? 16'(ask_px) : 16'd0),
                                   (bid_ok ? 16'(bid_px) : 16'd0),
                                   32'd0, 16'd0, 64'd0, 64'd0, status_reg};
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WRB: begin
                rem_left = bid_rem - q_reg;
                waddr    = bid_idx;
                wdata    = {1'b1, bid_px, bid_id, rem_left, bid_arr};
                if (rem_left == '0) begin
                    live_next[bid_idx] = 1'b0;
                end else begin
                    we = 1'b1;
                end
                state_next = ST_WRA;
            end
            ST_WRA: begin
                rem_left = ask_rem - q_reg;
                waddr    = ask_idx;
                wdata    = {1'b0, ask_px, ask_id, rem_left, ask_arr};
                if (rem_left == '0) begin
                    live_next[ask_idx] = 1'b0;
                end else begin
                    we = 1'b1;
                end
                phase_next = PH_BEST;
                cnt_next   = '0;
                clr        = 1'b1;
                state_next = ST_SCAN;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

### dv/tb.sv
// Testbench for the limit order matching engine: directed table and random orders vs. a predictor.
`timescale 1ns / 1ps
module tb import lome_pkg::*; ();

    localparam int SLOTS = 32;
    localparam int QD    = 4096;

    typedef struct packed {
        logic        action;
        logic [63:0] order_id;
        logic        is_buy;
        logic [15:0] limit_price;
        logic [31:0] order_quantity;
    } order_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [63:0] buyer_id;
        logic [63:0] seller_id;
        logic [15:0] trade_price;
        logic [31:0] trade_quantity;
        logic [15:0] top_bid;
        logic [15:0] top_ask;
        logic        last;
    } fill_t;

    typedef struct {
        order_t ord;
        logic   chk;
        fill_t  ack;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    limit_order_matching_engine u_top (.*);

    always #1 aclk = ~aclk;

    // predictor state
    logic        bk_live [SLOTS];
    logic        bk_buy  [SLOTS];
    logic [15:0] bk_price[SLOTS];
    logic [63:0] bk_id   [SLOTS];
    logic [31:0] bk_rem  [SLOTS];
    logic [31:0] bk_arr  [SLOTS];
    logic [31:0] arr_cnt;

    fill_t  exp_mem[QD];
    int     exp_wr = 0;
    int     exp_rd = 0;
    int     errors = 0;
    int     send_idle = 0;
    int     recv_stall = 0;
    logic [63:0] used_ids[64];
    int     used_n = 0;
    int     used_wr = 0;

    function automatic int best_side(logic buy);
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!bk_live[i] || bk_buy[i] != buy) continue;
            if (b < 0) begin
                b = i;
            end else if ((buy ? bk_price[i] > bk_price[b] : bk_price[i] < bk_price[b]) ||
                         (bk_price[i] == bk_price[b] &&
                          (arr_cnt - bk_arr[i]) > (arr_cnt - bk_arr[b]))) begin
                b = i;
            end
        end
        return b;
    endfunction

    function automatic int find_live(logic [63:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (bk_live[i] && bk_id[i] == id) return i;
        return -1;
    endfunction

    task automatic exp_add(fill_t f);
        exp_mem[exp_wr % QD] = f;
        exp_wr++;
    endtask

    task automatic predict_fills(order_t o);
        logic [1:0]  st;
        int          s, b, a;
        logic [31:0] q;
        fill_t       f;
        st = STAT_OK;
        if (o.action == ACT_CANCEL) begin
            s = find_live(o.order_id);
            if (s < 0) st = STAT_NOTFOUND;
            else bk_live[s] = 1'b0;
        end else if (find_live(o.order_id) >= 0) begin
            st = STAT_DUP;
        end else if (o.order_quantity != 0) begin
            s = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!bk_live[i]) s = i;
            if (s < 0) begin
                st = STAT_FULL;
            end else begin
                bk_live[s] = 1'b1;
                bk_buy[s] = o.is_buy;
                bk_price[s] = o.limit_price;
                bk_id[s] = o.order_id;
                bk_rem[s] = o.order_quantity;
                bk_arr[s] = arr_cnt;
                arr_cnt++;
                for (int g = 0; g < SLOTS; g++) begin
                    b = best_side(1'b1);
                    a = best_side(1'b0);
                    if (b < 0 || a < 0 || bk_price[b] < bk_price[a]) break;
                    q = bk_rem[b] < bk_rem[a] ? bk_rem[b] : bk_rem[a];
                    f = '0;
                    f.kind = KIND_TRADE;
                    f.buyer_id = bk_id[b];
                    f.seller_id = bk_id[a];
                    f.trade_price = bk_price[b];
                    f.trade_quantity = q;
                    exp_add(f);
                    bk_rem[b] -= q;
                    bk_rem[a] -= q;
                    if (bk_rem[b] == 0) bk_live[b] = 1'b0;
                    if (bk_rem[a] == 0) bk_live[a] = 1'b0;
                end
            end
        end
        b = best_side(1'b1);
        a = best_side(1'b0);
        f = '0;
        f.kind = KIND_ACK;
        f.status = st;
        f.top_bid = b < 0 ? 16'd0 : bk_price[b];
        f.top_ask = a < 0 ? 16'd0 : bk_price[a];
        f.last = 1'b1;
        exp_add(f);
    endtask

    task automatic send_order(order_t o);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= o.action;
        s_tdata <= {7'd0, o.order_quantity, o.limit_price, o.is_buy, o.order_id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_fills(o);
    endtask

    always @(posedge aclk) begin
        fill_t got, want;
        m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.status = m_tdata[1:0];
            got.buyer_id = m_tdata[65:2];
            got.seller_id = m_tdata[129:66];
            got.trade_price = m_tdata[145:130];
            got.trade_quantity = m_tdata[177:146];
            got.top_bid = m_tdata[193:178];
            got.top_ask = m_tdata[209:194];
            got.last = m_tlast;
            if (exp_wr == exp_rd) begin
                $display("%0t unexpected result: actual %h", $time, got);
                errors++;
            end else begin
                want = exp_mem[exp_rd % QD];
                exp_rd++;
                if (got !== want) begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    function automatic order_t mk(logic act, logic [63:0] id, logic buy,
                                  logic [15:0] px, logic [31:0] qty);
        order_t o;
        o.action = act;
        o.order_id = id;
        o.is_buy = buy;
        o.limit_price = px;
        o.order_quantity = qty;
        return o;
    endfunction

    function automatic fill_t mk_ack(logic [1:0] st, logic [15:0] bid, logic [15:0] ask);
        fill_t f;
        f = '0;
        f.kind = KIND_ACK;
        f.status = st;
        f.top_bid = bid;
        f.top_ask = ask;
        f.last = 1'b1;
        return f;
    endfunction

    function automatic logic [63:0] rand_id();
        if (used_n > 0 && $urandom_range(3) == 0)
            return used_ids[$urandom_range(used_n - 1)];
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_order();
        order_t o;
        int r;
        r = $urandom_range(99);
        o.order_id = rand_id();
        o.is_buy = 1'($urandom_range(1));
        o.limit_price = 16'(16'd1000 + $urandom_range(20) - 10);
        if ($urandom_range(15) == 0) o.limit_price = 16'($urandom());
        o.order_quantity = $urandom_range(1, 200);
        if ($urandom_range(15) == 0) o.order_quantity = $urandom();
        if ($urandom_range(31) == 0) o.order_quantity = 0;
        o.action = (r < 25) ? ACT_CANCEL : ACT_ADD;
        used_ids[used_wr] = o.order_id;
        used_wr = (used_wr + 1) % 64;
        if (used_n < 64) used_n++;
        send_order(o);
    endtask

    row_t rows[64];
    int   n_rows = 0;

    task automatic add_row(row_t r);
        rows[n_rows] = r;
        n_rows++;
    endtask

    task automatic drain();
        int w;
        w = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (exp_wr != exp_rd && w < 200000) begin
            @(posedge aclk);
            w++;
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) bk_live[i] = 1'b0;
        arr_cnt = '0;
        // empty book, extremes, cancel miss, dup, zero quantity
        add_row('{mk(ACT_CANCEL, 64'h0, 1'b0, 16'h0, 32'd0), 1'b1,
                  mk_ack(STAT_NOTFOUND, 16'd0, 16'd0)});
        add_row('{mk(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'hFFFF, 32'd0), 1'b1,
                  mk_ack(STAT_OK, 16'd0, 16'd0)});
        add_row('{mk(ACT_ADD, 64'h1, 1'b1, 16'd100, 32'hFFFF_FFFF), 1'b1,
                  mk_ack(STAT_OK, 16'd100, 16'd0)});
        add_row('{mk(ACT_ADD, 64'h1, 1'b0, 16'd50, 32'd5), 1'b1,
                  mk_ack(STAT_DUP, 16'd100, 16'd0)});
        add_row('{mk(ACT_ADD, 64'h2, 1'b0, 16'd200, 32'd5), 1'b1,
                  mk_ack(STAT_OK, 16'd100, 16'd200)});
        add_row('{mk(ACT_ADD, 64'h3, 1'b1, 16'd100, 32'd7), 1'b0, '0});
        add_row('{mk(ACT_ADD, 64'h4, 1'b0, 16'd90, 32'd3), 1'b0, '0});
        add_row('{mk(ACT_ADD, 64'h5, 1'b1, 16'hFFFF, 32'd10), 1'b0, '0});
        add_row('{mk(ACT_ADD, 64'h6, 1'b0, 16'd0, 32'hFFFF_FFFF), 1'b0, '0});
        add_row('{mk(ACT_CANCEL, 64'h6, 1'b0, 16'd0, 32'd0), 1'b0, '0});
        add_row('{mk(ACT_CANCEL, 64'h2, 1'b1, 16'hFFFF, 32'd1), 1'b0, '0});
        add_row('{mk(ACT_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0, 32'd0), 1'b0,
                  '0});
        for (int i = 0; i < 33; i++)
            add_row('{mk(ACT_ADD, 64'h100 + i, 1'b1, 16'd10, 32'd1), 1'b0, '0});
        add_row('{mk(ACT_ADD, 64'h200, 1'b0, 16'd10, 32'd40), 1'b0, '0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < n_rows; i++) begin
            send_order(rows[i].ord);
            if (rows[i].chk && exp_mem[(exp_wr - 1) % QD] !== rows[i].ack) begin
                $display("%0t table row %0d: expected %h actual %h", $time, i,
                         rows[i].ack, exp_mem[(exp_wr - 1) % QD]);
                errors++;
            end
        end
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 28 : 70) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 28 : 70) : 0;
            for (int n = 0; n < 55; n++) random_order();
            // let all results settle once mid-run
            if (ph == 1) drain();
        end
        for (int n = 0; n < 44; n++) random_order();
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0 && exp_wr == exp_rd) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
rtl/lome_pkg.sv
rtl/lome_ram.sv
rtl/lome_scan.sv
rtl/limit_order_matching_engine.sv
dv/tb.sv
